### design/lwpm_pkg.sv
// lwpm_pkg: shared types and constants for the latency window percentile monitor
// transaction structs for both channels plus the sorted chain entry type
// no dependencies
`default_nettype none

package lwpm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned TotalW  = 40;
  localparam int unsigned SumW    = 64;
  localparam int unsigned RetW    = 9;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};

  // percentile index is (n-1)*PctNum/PctDen
  localparam int unsigned PctNum = 99;
  localparam int unsigned PctDen = 100;
  localparam int unsigned RemW   = 8;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [SampleW-1:0] sample_us;
  } lwpm_in_t;

  typedef struct packed {
    logic               empty_res;
    logic [TotalW-1:0]  sample_count;
    logic [RetW-1:0]    retained;
    logic [SampleW-1:0] min_us;
    logic [SampleW-1:0] max_us;
    logic [SumW-1:0]    sum_us;
    logic [SampleW-1:0] p99_us;
  } lwpm_out_t;

  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] value;
  } lwpm_entry_t;

endpackage

`default_nettype wire

### design/lwpm_cell.sv
// lwpm_cell: one slot of the sorted window chain
// removes the evicted value and inserts the new one using only neighbour data
// depends on lwpm_pkg
`default_nettype none

module lwpm_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 shift_en_i,
  input  wire logic                 evict_i,
  input  wire logic [31:0]          old_i,
  input  wire logic [31:0]          smp_i,
  input  wire lwpm_pkg::lwpm_entry_t prev_rm_i,
  input  wire logic                 prev_gt_i,
  input  wire lwpm_pkg::lwpm_entry_t nxt_i,
  output lwpm_pkg::lwpm_entry_t      cur_o,
  output lwpm_pkg::lwpm_entry_t      rm_o,
  output logic                      gt_o
);
  import lwpm_pkg::*;

  logic               valid_q, valid_d;
  logic [SampleW-1:0] value_q, value_d;
  lwpm_entry_t        cur;
  lwpm_entry_t        rm;
  logic               ge;
  logic               gt;

  always_comb begin
    cur.valid = valid_q;
    cur.value = value_q;
    // first slot at or above the evicted value and everything above it move down
    ge = evict_i && cur.valid && (cur.value >= old_i);
    rm = ge ? nxt_i : cur;
    gt = !rm.valid || (rm.value > smp_i);
    if (!gt) begin
      valid_d = rm.valid;
      value_d = rm.value;
    end else if (prev_gt_i) begin
      valid_d = prev_rm_i.valid;
      value_d = prev_rm_i.value;
    end else begin
      valid_d = 1'b1;
      value_d = smp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      value_q <= value_d;
    end
  end

  assign cur_o = cur;
  assign rm_o  = rm;
  assign gt_o  = gt;

endmodule

`default_nettype wire

### design/lwpm_sorted_chain.sv
// lwpm_sorted_chain: row of WINDOW cells holding the window in ascending order
// selects the entry at the percentile index for the summary
// depends on lwpm_pkg and lwpm_cell
`default_nettype none

module lwpm_sorted_chain #(
  parameter int unsigned WINDOW = 256,
  parameter int unsigned IdxW   = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_en_i,
  input  wire logic            evict_i,
  input  wire logic [31:0]     old_i,
  input  wire logic [31:0]     smp_i,
  input  wire logic [IdxW-1:0] sel_i,
  output logic [31:0]          sel_value_o
);
  import lwpm_pkg::*;

  lwpm_entry_t cur [WINDOW];
  lwpm_entry_t rm  [WINDOW];
  logic        gt  [WINDOW];
  lwpm_entry_t empty_entry;

  assign empty_entry = '{valid: 1'b0, value: '0};

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    lwpm_entry_t prev_rm;
    logic        prev_gt;
    lwpm_entry_t nxt;

    if (g == 0) begin : g_first
      assign prev_rm = empty_entry;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_rm = rm[g-1];
      assign prev_gt = gt[g-1];
    end

    if (g == WINDOW - 1) begin : g_last
      assign nxt = empty_entry;
    end else begin : g_up
      assign nxt = cur[g+1];
    end

    lwpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en_i),
      .evict_i    (evict_i),
      .old_i      (old_i),
      .smp_i      (smp_i),
      .prev_rm_i  (prev_rm),
      .prev_gt_i  (prev_gt),
      .nxt_i      (nxt),
      .cur_o      (cur[g]),
      .rm_o       (rm[g]),
      .gt_o       (gt[g])
    );
  end

  assign sel_value_o = cur[sel_i].value;

endmodule

`default_nettype wire

### design/latency_window_percentile_monitor.sv
// latency_window_percentile_monitor: top level of the sliding window latency monitor
// holds the arrival ring, running statistics and the summary output register
// depends on lwpm_pkg and lwpm_sorted_chain
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) carries transactions of
//   kind sample or query. a sample is folded into the window and statistics in
//   the cycle it is accepted and gives no output. a query loads a summary
//   into the output register, shown on out_valid_o / out_data_o the next cycle.
//   one transaction per cycle is taken while in_stall_o is low: every cell of the
//   sorted chain shifts in parallel, so a sample never waits on the window size.
//   while a summary is held stalled by out_stall_i, in_stall_o is raised and
//   the held summary does not change.
//   reset empties the window and clears the count, sum and extremes; no
//   clearing pass is needed, the block takes transactions right after reset.
//   the arrival ring is a WINDOW deep memory read one transaction ahead.
`default_nettype none

module latency_window_percentile_monitor #(
  parameter int unsigned WINDOW = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire lwpm_pkg::lwpm_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lwpm_pkg::lwpm_out_t      out_data_o
);
  import lwpm_pkg::*;

  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);

  logic               in_acc;
  logic               smp_acc;
  logic               qry_acc;

  logic [SampleW-1:0] ring [WINDOW];
  logic [SampleW-1:0] ring_rd_q;
  logic [IdxW-1:0]    wp_q, wp_d;

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               full;
  logic [IdxW-1:0]    pidx_q, pidx_d;
  logic [RemW-1:0]    prem_q, prem_d;
  logic [RemW-1:0]    prem_sum;

  logic [TotalW-1:0]  total_q, total_d;
  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] max_q, max_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SumW:0]      sum_add;

  logic [SampleW-1:0] p99_val;
  logic               empty;

  logic               out_valid_q;
  lwpm_out_t          out_q, out_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign smp_acc    = in_acc && (in_data_i.kind == KIND_SAMPLE);
  assign qry_acc    = in_acc && (in_data_i.kind == KIND_QUERY);

  assign full  = (cnt_q == CntW'(WINDOW));
  assign empty = (total_q == '0);

  lwpm_sorted_chain #(
    .WINDOW (WINDOW),
    .IdxW   (IdxW)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_en_i  (smp_acc),
    .evict_i     (full),
    .old_i       (ring_rd_q),
    .smp_i       (in_data_i.sample_us),
    .sel_i       (pidx_q),
    .sel_value_o (p99_val)
  );

  // ring position and window fill
  always_comb begin
    wp_d     = wp_q;
    cnt_d    = cnt_q;
    pidx_d   = pidx_q;
    prem_d   = prem_q;
    prem_sum = prem_q + RemW'(PctNum);
    if (smp_acc) begin
      wp_d = (wp_q == IdxW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (!full) begin
        cnt_d = cnt_q + 1'b1;
        // percentile index steps by PctNum/PctDen per extra retained sample
        if (cnt_q != '0) begin
          if (prem_sum >= RemW'(PctDen)) begin
            prem_d = prem_sum - RemW'(PctDen);
            pidx_d = pidx_q + 1'b1;
          end else begin
            prem_d = prem_sum;
          end
        end
      end
    end
  end

  // running statistics
  always_comb begin
    total_d = total_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    sum_add = {1'b0, sum_q} + {{(SumW + 1 - SampleW){1'b0}}, in_data_i.sample_us};
    if (smp_acc) begin
      if (total_q != TotalMax) begin
        total_d = total_q + 1'b1;
      end
      if (in_data_i.sample_us < min_q) begin
        min_d = in_data_i.sample_us;
      end
      if (in_data_i.sample_us > max_q) begin
        max_d = in_data_i.sample_us;
      end
      sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
    end
  end

  always_comb begin
    out_d.empty_res    = empty;
    out_d.sample_count = total_q;
    out_d.retained     = RetW'(cnt_q);
    out_d.min_us       = empty ? '0 : min_q;
    out_d.max_us       = empty ? '0 : max_q;
    out_d.sum_us       = sum_q;
    out_d.p99_us       = empty ? '0 : p99_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      cnt_q   <= '0;
      pidx_q  <= '0;
      prem_q  <= '0;
      total_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      sum_q   <= '0;
    end else begin
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      pidx_q  <= pidx_d;
      prem_q  <= prem_d;
      total_q <= total_d;
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
    end
  end

  // arrival ring: read the slot the next sample will overwrite
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      ring[wp_q] <= in_data_i.sample_us;
    end
    if (smp_acc && (wp_d == wp_q)) begin
      ring_rd_q <= in_data_i.sample_us;
    end else begin
      ring_rd_q <= ring[wp_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (qry_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### sim/latency_window_percentile_monitor_tb.sv
// latency_window_percentile_monitor_tb: self-checking bench for the sliding window latency monitor
// directed table then random samples and queries, checked against fixed values or a local mirror
// depends on lwpm_pkg and latency_window_percentile_monitor
`default_nettype none

module latency_window_percentile_monitor_tb;
  import lwpm_pkg::*;

  localparam int unsigned Win = 256;

  typedef struct {
    lwpm_in_t  txn;
    bit        typed;
    lwpm_out_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lwpm_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lwpm_out_t out_data;

  // mirror of the window and running statistics
  logic [SampleW-1:0] ring_mem [Win];
  logic [SampleW-1:0] sorted_q [$];
  int unsigned        wr_pos     = 0;
  logic [TotalW-1:0]  seen_total = '0;
  logic [SampleW-1:0] seen_min   = '1;
  logic [SampleW-1:0] seen_max   = '0;
  logic [SumW-1:0]    seen_sum   = '0;

  lwpm_out_t   summary_q [$];
  int unsigned errors       = 0;
  int unsigned samples_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned results_seen = 0;
  int unsigned stall_left   = 0;
  bit          send_idle    = 1'b0;
  bit          recv_idle    = 1'b0;

  latency_window_percentile_monitor #(
    .WINDOW(Win)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #2 clk = ~clk;

  task automatic fold_sample(input logic [SampleW-1:0] v);
    int unsigned at;
    int unsigned i;
    // full window: drop the oldest value from the sorted copy first
    if (sorted_q.size() == Win) begin
      at = Win - 1;
      for (i = 0; i < Win; i++) begin
        if (sorted_q[i] == ring_mem[wr_pos]) begin
          at = i;
          break;
        end
      end
      sorted_q.delete(at);
    end
    at = sorted_q.size();
    for (i = 0; i < sorted_q.size(); i++) begin
      if (sorted_q[i] > v) begin
        at = i;
        break;
      end
    end
    sorted_q.insert(at, v);
    ring_mem[wr_pos] = v;
    wr_pos = (wr_pos + 1) % Win;
    if (seen_total != TotalMax) seen_total++;
    if (v < seen_min) seen_min = v;
    if (v > seen_max) seen_max = v;
    if (seen_sum > SumMax - {32'b0, v}) seen_sum = SumMax;
    else seen_sum = seen_sum + {32'b0, v};
  endtask

  function automatic lwpm_out_t expected_summary();
    lwpm_out_t   s;
    int unsigned n;
    s = '0;
    n = sorted_q.size();
    s.sample_count = seen_total;
    s.retained = n[RetW-1:0];
    s.sum_us = seen_sum;
    if (seen_total == '0) begin
      s.empty_res = 1'b1;
    end else begin
      s.min_us = seen_min;
      s.max_us = seen_max;
      s.p99_us = sorted_q[((n - 1) * PctNum) / PctDen];
    end
    return s;
  endfunction

  function automatic dir_row_t mk_row(input kind_e k, input logic [SampleW-1:0] v,
                                      input bit typed = 1'b0, input lwpm_out_t want = '0);
    dir_row_t r;
    r.txn.kind = k;
    r.txn.sample_us = v;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic send_txn(input lwpm_in_t t, input bit typed, input lwpm_out_t want);
    int unsigned gap;
    @(negedge clk);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      in_data <= lwpm_in_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    if (t.kind == KIND_QUERY) begin
      summary_q.insert(summary_q.size(), typed ? want : expected_summary());
      queries_sent++;
    end else begin
      fold_sample(t.sample_us);
      samples_sent++;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // random result stall bursts while recv_idle is set
  always @(negedge clk) begin
    if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0)
      stall_left = $urandom_range(1, 6);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin : check_result
    lwpm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (summary_q.size() == 0) begin
        $error("summary transaction with none expected");
        errors++;
      end else begin
        want = summary_q[0];
        summary_q.delete(0);
        check_field("empty_res", 64'(want.empty_res), 64'(out_data.empty_res));
        check_field("sample_count", 64'(want.sample_count), 64'(out_data.sample_count));
        check_field("retained", 64'(want.retained), 64'(out_data.retained));
        check_field("min_us", 64'(want.min_us), 64'(out_data.min_us));
        check_field("max_us", 64'(want.max_us), 64'(out_data.max_us));
        check_field("sum_us", want.sum_us, out_data.sum_us);
        check_field("p99_us", 64'(want.p99_us), 64'(out_data.p99_us));
        results_seen++;
      end
    end
  end

  initial begin : stimulus
    dir_row_t    rows [$];
    lwpm_in_t    t;
    int unsigned roll;
    int unsigned phase;

    // empty summary, extremes, duplicates, back-to-back queries, ignored sample field
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'h0, 1'b1,
                '{1'b1, 40'd0, 9'd0, 32'h0, 32'h0, 64'h0, 32'h0}));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'h0));
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'h0, 1'b1,
                '{1'b0, 40'd1, 9'd1, 32'h0, 32'h0, 64'h0, 32'h0}));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'hFFFF_FFFF));
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'h0, 1'b1,
                '{1'b0, 40'd2, 9'd2, 32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF, 32'h0}));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'hFFFF_FFFF));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'h1));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'h8000_0000));
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'h0));
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'h0));
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'hFFFF_FFFF));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'h5555_5555));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'hAAAA_AAAA));
    rows.insert(rows.size(), mk_row(KIND_SAMPLE, 32'h1));
    rows.insert(rows.size(), mk_row(KIND_QUERY, 32'h7FFF_FFFF));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (rows[i]) send_txn(rows[i].txn, rows[i].typed, rows[i].want);

    // phases: both sides idle, sender only, receiver only, then flat out
    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 0 || phase == 1);
      recv_idle = (phase == 0 || phase == 2);
      repeat (470) begin
        t.kind = ($urandom_range(0, 5) == 0) ? KIND_QUERY : KIND_SAMPLE;
        roll = $urandom_range(0, 9);
        case (roll)
          0: t.sample_us = '0;
          1: t.sample_us = '1;
          2, 3: t.sample_us = $urandom_range(0, 15);
          4: t.sample_us = 32'hFFFF_FFFF - $urandom_range(0, 15);
          default: t.sample_us = $urandom;
        endcase
        send_txn(t, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d samples and %0d queries sent, %0d summaries checked",
             samples_sent, queries_sent, results_seen);
    $display("window of %0d refilled about %0d times, duplicates and extremes mixed in",
             Win, samples_sent / Win);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
